/* rtl/bvpr_pkg.sv */
// Package of shared constants, types and codes for the button vote block.
`default_nettype none
package bvpr_pkg;

    // Number of button codes that take part in a vote (2 to 255).
    localparam int NUM_CODES = 20;
    localparam int IDX_W     = $clog2(NUM_CODES);

    localparam int BIN_W     = 4;
    localparam logic [BIN_W-1:0] BIN_MAX = '1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_READS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEVEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE_CODE    = 2'd3;

    // Configuration reset values.
    localparam logic [3:0] RST_WINDOW_READS  = 4'd10;
    localparam logic [3:0] RST_MIN_HITS      = 4'd7;
    localparam logic [7:0] RST_RELEASE_LEVEL = 8'd250;
    localparam logic [7:0] RST_VOICE_CODE    = 8'd0;

    // Request kinds.
    localparam logic [2:0] REQ_DETECT   = 3'd0;
    localparam logic [2:0] REQ_SAMPLE   = 3'd1;
    localparam logic [2:0] REQ_VOICE    = 3'd2;
    localparam logic [2:0] REQ_BTN_EN   = 3'd3;
    localparam logic [2:0] REQ_VOICE_EN = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WINDOW = 2'd1,
        PH_HELD   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_PICK = 2'd1,
        ST_SEND = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic step;   // apply the accepted item
        logic pick;   // close the window: choose the winning code
    } dp_cmd_t;

    typedef struct packed {
        logic close;  // the item just applied ends the voting window
        logic emit;   // the item just applied produces an event
        logic found;  // some code reached the minimum vote count
    } dp_status_t;

endpackage
`default_nettype wire

/* rtl/bvpr_dp.sv */
// Datapath: configuration, vote bins, block phase and the result register.
`default_nettype none
module bvpr_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bvpr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bvpr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [2:0]                        req_type,
    input  wire logic [7:0]                        sample_id,
    input  wire logic                              flag_level,
    input  wire logic                              port_power,
    input  wire logic [31:0]                       time_stamp,
    input  wire bvpr_pkg::dp_cmd_t                 cmd,
    output bvpr_pkg::dp_status_t                   status,
    output logic                                   res_pressed,
    output logic [7:0]                             res_code,
    output logic                                   res_power,
    output logic [31:0]                            res_time
);

    logic [3:0] window_reads_reg;
    logic [3:0] min_hits_reg;
    logic [7:0] release_level_reg;
    logic [7:0] voice_code_reg;

    bvpr_pkg::phase_t phase_reg, phase_next;
    logic [3:0] samples_reg, samples_next;
    logic [bvpr_pkg::BIN_W-1:0] bins_reg  [bvpr_pkg::NUM_CODES];
    logic [bvpr_pkg::BIN_W-1:0] bins_next [bvpr_pkg::NUM_CODES];
    logic [7:0] held_reg, held_next;
    logic       btn_online_reg, btn_online_next;
    logic       voice_online_reg, voice_online_next;

    logic        pressed_reg, pressed_next;
    logic [7:0]  code_reg, code_next;
    logic        power_reg, power_next;
    logic [31:0] time_reg, time_next;

    logic                       id_valid;
    logic [bvpr_pkg::IDX_W-1:0] id_idx;
    logic                       close_c;
    logic                       emit_c;
    logic                       found_c;
    logic [7:0]                 win_code;

    assign id_valid = (sample_id < 8'(bvpr_pkg::NUM_CODES));
    assign id_idx   = sample_id[bvpr_pkg::IDX_W-1:0];

    // Lowest code whose bin has reached the minimum.
    always_comb begin
        found_c  = 1'b0;
        win_code = '0;
        for (int i = bvpr_pkg::NUM_CODES - 1; i >= 0; i--) begin
            if (bins_reg[i] >= min_hits_reg) begin
                found_c  = 1'b1;
                win_code = 8'(i);
            end
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        samples_next      = samples_reg;
        bins_next         = bins_reg;
        held_next         = held_reg;
        btn_online_next   = btn_online_reg;
        voice_online_next = voice_online_reg;
        pressed_next      = pressed_reg;
        code_next         = code_reg;
        power_next        = power_reg;
        time_next         = time_reg;
        close_c           = 1'b0;
        emit_c            = 1'b0;

        if (cmd.step) begin
            // Power and time are kept for an event made at window close.
            power_next = port_power;
            time_next  = time_stamp;
            case (req_type)
                bvpr_pkg::REQ_DETECT: begin
                    if (btn_online_reg && phase_reg == bvpr_pkg::PH_IDLE) begin
                        for (int i = 0; i < bvpr_pkg::NUM_CODES; i++) begin
                            bins_next[i] = '0;
                        end
                        samples_next = '0;
                        phase_next   = bvpr_pkg::PH_WINDOW;
                    end
                end
                bvpr_pkg::REQ_SAMPLE: begin
                    if (phase_reg == bvpr_pkg::PH_WINDOW) begin
                        if (id_valid && bins_reg[id_idx] != bvpr_pkg::BIN_MAX) begin
                            bins_next[id_idx] = bins_reg[id_idx] + 1'b1;
                        end
                        if (samples_reg != 4'hF) begin
                            samples_next = samples_reg + 4'd1;
                        end
                        close_c = (samples_next >= window_reads_reg);
                    end else if (phase_reg == bvpr_pkg::PH_HELD) begin
                        if (sample_id >= release_level_reg) begin
                            phase_next   = bvpr_pkg::PH_IDLE;
                            emit_c       = 1'b1;
                            pressed_next = 1'b0;
                            code_next    = held_reg;
                        end
                    end
                end
                bvpr_pkg::REQ_VOICE: begin
                    if (voice_online_reg) begin
                        emit_c       = 1'b1;
                        pressed_next = ~flag_level;
                        code_next    = voice_code_reg;
                    end
                end
                bvpr_pkg::REQ_BTN_EN: begin
                    if (flag_level) begin
                        btn_online_next = 1'b1;
                    end else if (btn_online_reg) begin
                        btn_online_next = 1'b0;
                        phase_next      = bvpr_pkg::PH_IDLE;
                        if (phase_reg == bvpr_pkg::PH_HELD) begin
                            emit_c       = 1'b1;
                            pressed_next = 1'b0;
                            code_next    = held_reg;
                        end
                    end
                end
                bvpr_pkg::REQ_VOICE_EN: begin
                    voice_online_next = flag_level;
                end
                default: begin
                end
            endcase
        end else if (cmd.pick) begin
            if (found_c) begin
                held_next    = win_code;
                phase_next   = bvpr_pkg::PH_HELD;
                pressed_next = 1'b1;
                code_next    = win_code;
            end else begin
                phase_next = bvpr_pkg::PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reads_reg  <= bvpr_pkg::RST_WINDOW_READS;
            min_hits_reg      <= bvpr_pkg::RST_MIN_HITS;
            release_level_reg <= bvpr_pkg::RST_RELEASE_LEVEL;
            voice_code_reg    <= bvpr_pkg::RST_VOICE_CODE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bvpr_pkg::CFG_WINDOW_READS:  window_reads_reg  <= cfg_data[3:0];
                bvpr_pkg::CFG_MIN_HITS:      min_hits_reg      <= cfg_data[3:0];
                bvpr_pkg::CFG_RELEASE_LEVEL: release_level_reg <= cfg_data;
                bvpr_pkg::CFG_VOICE_CODE:    voice_code_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= bvpr_pkg::PH_IDLE;
            samples_reg      <= '0;
            held_reg         <= '0;
            btn_online_reg   <= 1'b0;
            voice_online_reg <= 1'b0;
            for (int i = 0; i < bvpr_pkg::NUM_CODES; i++) begin
                bins_reg[i] <= '0;
            end
        end else begin
            phase_reg        <= phase_next;
            samples_reg      <= samples_next;
            held_reg         <= held_next;
            btn_online_reg   <= btn_online_next;
            voice_online_reg <= voice_online_next;
            bins_reg         <= bins_next;
        end
    end

    always_ff @(posedge aclk) begin
        pressed_reg <= pressed_next;
        code_reg    <= code_next;
        power_reg   <= power_next;
        time_reg    <= time_next;
    end

    assign status.close = close_c;
    assign status.emit  = emit_c;
    assign status.found = found_c;

    assign res_pressed = pressed_reg;
    assign res_code    = code_reg;
    assign res_power   = power_reg;
    assign res_time    = time_reg;

endmodule
`default_nettype wire

/* rtl/bvpr_ctrl.sv */
// Controller: sequences item intake, window close and result delivery.
`default_nettype none
module bvpr_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output bvpr_pkg::dp_cmd_t         cmd,
    input  wire bvpr_pkg::dp_status_t status
);

    bvpr_pkg::ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bvpr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (status.close) begin
                        state_next = bvpr_pkg::ST_PICK;
                    end else if (status.emit) begin
                        state_next = bvpr_pkg::ST_SEND;
                    end
                end
            end
            bvpr_pkg::ST_PICK: begin
                state_next = status.found ? bvpr_pkg::ST_SEND : bvpr_pkg::ST_IDLE;
            end
            bvpr_pkg::ST_SEND: begin
                if (m_tready) begin
                    state_next = bvpr_pkg::ST_IDLE;
                end
            end
            default: state_next = bvpr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        cmd.step = 1'b0;
        cmd.pick = 1'b0;
        unique case (state_reg)
            bvpr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.step = s_tvalid;
            end
            bvpr_pkg::ST_PICK: cmd.pick = 1'b1;
            bvpr_pkg::ST_SEND: m_tvalid = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bvpr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/button_vote_press_release_core.sv */
// Top level of the button vote block: press and release events by majority vote.
//
//  channel  | direction | tdata (low bit up)                          | tuser
//  ---------+-----------+---------------------------------------------+-----------
//  s_       | in        | sample_id, flag_level, port_power, time_stamp| req_type
//  m_       | out       | button_code, event_power, event_time        | pressed
//  cfg_     | in        | write enable, register index, data          | -
//
// An item that produces no event or a direct event is applied as it is taken; an
// event is then held in the output register until it is taken. A sample that
// closes the voting window then passes through the pick state, in which the bin compare and
// lowest-code pick run on the registered vote bins. The block takes one item at
// a time, so the input is ready again only after the result has left.
// Reset is synchronous and active low; it clears the bins, the phase and all
// control state and loads the register defaults.
`default_nettype none
module button_vote_press_release_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Configuration writes.
    input  wire logic                                 cfg_wr_en,
    input  wire logic [bvpr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bvpr_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Input items.
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // sample_id[7:0], flag_level[8], port_power[9], time_stamp[41:10], zero pad
    input  wire logic [bvpr_pkg::S_TDATA_W-1:0]       s_tdata,
    // req_type[2:0]
    input  wire logic [bvpr_pkg::S_TUSER_W-1:0]       s_tuser,
    // Result items.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // button_code[7:0], event_power[8], event_time[40:9], zero pad
    output logic [bvpr_pkg::M_TDATA_W-1:0]            m_tdata,
    // pressed[0]
    output logic [bvpr_pkg::M_TUSER_W-1:0]            m_tuser
);

    bvpr_pkg::dp_cmd_t    cmd;
    bvpr_pkg::dp_status_t status;

    logic        res_pressed;
    logic [7:0]  res_code;
    logic        res_power;
    logic [31:0] res_time;

    bvpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    bvpr_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (s_tuser[2:0]),
        .sample_id   (s_tdata[7:0]),
        .flag_level  (s_tdata[8]),
        .port_power  (s_tdata[9]),
        .time_stamp  (s_tdata[41:10]),
        .cmd         (cmd),
        .status      (status),
        .res_pressed (res_pressed),
        .res_code    (res_code),
        .res_power   (res_power),
        .res_time    (res_time)
    );

    // The unused upper bits of the output are held at zero.
    assign m_tdata = {7'd0, res_time, res_power, res_code};
    assign m_tuser = res_pressed;

endmodule
`default_nettype wire

/* tb/bvpr_event_checker.sv */
// Checker that predicts press and release events and compares them with the result channel.
module bvpr_event_checker
    import bvpr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_TDATA_W-1:0]  m_tdata,
    input  wire logic [M_TUSER_W-1:0]  m_tuser,
    output int                         fail_count,
    output int                         pending_count,
    output int                         press_count,
    output int                         release_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        pressed;
        logic [7:0]  button_code;
        logic        event_power;
        logic [31:0] event_time;
    } button_event_t;

    // Register copies.
    logic [3:0] window_reads;
    logic [3:0] min_hits;
    logic [7:0] release_level;
    logic [7:0] voice_code;

    // Vote state.
    phase_t     phase;
    logic [3:0] samples_taken;
    logic [3:0] vote_bins [NUM_CODES];
    logic [7:0] held_button;
    logic       buttons_online;
    logic       voice_online;

    button_event_t awaited_events [$];

    // Applies one accepted item to the vote state and queues the event it causes, if any.
    task automatic apply_request(input logic [2:0] req, input logic [7:0] id,
                                 input logic flag, input logic power,
                                 input logic [31:0] stamp);
        button_event_t ev;
        bit            emits;
        bit            found;
        int            c;
        emits          = 1'b0;
        found          = 1'b0;
        ev.pressed     = 1'b0;
        ev.button_code = held_button;
        ev.event_power = power;
        ev.event_time  = stamp;
        case (req)
            REQ_DETECT: begin
                if (buttons_online && phase == PH_IDLE) begin
                    foreach (vote_bins[b]) vote_bins[b] = '0;
                    samples_taken = '0;
                    phase         = PH_WINDOW;
                end
            end
            REQ_SAMPLE: begin
                if (phase == PH_WINDOW) begin
                    if (id < NUM_CODES) begin
                        if (vote_bins[id] != BIN_MAX) vote_bins[id] = vote_bins[id] + 1'b1;
                    end
                    if (samples_taken != 4'hF) samples_taken = samples_taken + 1'b1;
                    if (samples_taken >= window_reads) begin
                        // Lowest code that reached the vote threshold wins.
                        for (c = 0; c < NUM_CODES && !found; c++) begin
                            if (vote_bins[c] >= min_hits) begin
                                found       = 1'b1;
                                held_button = 8'(c);
                            end
                        end
                        if (found) begin
                            phase          = PH_HELD;
                            emits          = 1'b1;
                            ev.pressed     = 1'b1;
                            ev.button_code = held_button;
                        end else begin
                            phase = PH_IDLE;
                        end
                    end
                end else if (phase == PH_HELD && id >= release_level) begin
                    phase = PH_IDLE;
                    emits = 1'b1;
                end
            end
            REQ_VOICE: begin
                if (voice_online) begin
                    emits          = 1'b1;
                    ev.pressed     = ~flag;
                    ev.button_code = voice_code;
                end
            end
            REQ_BTN_EN: begin
                if (flag) begin
                    buttons_online = 1'b1;
                end else if (buttons_online) begin
                    buttons_online = 1'b0;
                    if (phase == PH_HELD) emits = 1'b1;
                    phase = PH_IDLE;
                end
            end
            REQ_VOICE_EN: voice_online = flag;
            default: ;
        endcase
        if (emits) awaited_events.push_back(ev);
    endtask

    function automatic bit field_differs(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want === got) return 1'b0;
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        button_event_t seen;
        button_event_t want;
        bit            bad;
        if (!aresetn) begin
            window_reads   = RST_WINDOW_READS;
            min_hits       = RST_MIN_HITS;
            release_level  = RST_RELEASE_LEVEL;
            voice_code     = RST_VOICE_CODE;
            phase          = PH_IDLE;
            samples_taken  = '0;
            foreach (vote_bins[b]) vote_bins[b] = '0;
            held_button    = '0;
            buttons_online = 1'b0;
            voice_online   = 1'b0;
            awaited_events.delete();
            fail_count     = 0;
            press_count    = 0;
            release_count  = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_WINDOW_READS:  window_reads  = cfg_data[3:0];
                    CFG_MIN_HITS:      min_hits      = cfg_data[3:0];
                    CFG_RELEASE_LEVEL: release_level = cfg_data[7:0];
                    CFG_VOICE_CODE:    voice_code    = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser[2:0], s_tdata[7:0], s_tdata[8], s_tdata[9],
                              s_tdata[41:10]);
            end
            if (m_tvalid && m_tready) begin
                seen.pressed     = m_tuser[0];
                seen.button_code = m_tdata[7:0];
                seen.event_power = m_tdata[8];
                seen.event_time  = m_tdata[40:9];
                if (awaited_events.size() == 0) begin
                    $error("unexpected event: pressed %0d button_code %0d power %0d time 0x%0h",
                           seen.pressed, seen.button_code, seen.event_power, seen.event_time);
                    fail_count++;
                end else begin
                    want = awaited_events.pop_front();
                    bad  = field_differs("pressed", want.pressed, seen.pressed)
                         | field_differs("button_code", want.button_code, seen.button_code)
                         | field_differs("event_power", want.event_power, seen.event_power)
                         | field_differs("event_time", want.event_time, seen.event_time);
                    if (bad) fail_count++;
                    if (seen.pressed) press_count++;
                    else release_count++;
                end
            end
        end
        pending_count = awaited_events.size();
    end

endmodule

/* tb/testbench.sv */
// Top of the button vote testbench: clock, reset, stimulus, result pacing and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bvpr_pkg::*;

    localparam int CLK_PERIOD    = 10;
    // Items to send apart from filler; filler items come on top of these.
    localparam int RANDOM_ITEMS  = 1450;
    localparam int ITEMS_PER_SET = 180;
    // A closing sample passes through an extra pick state; this covers it with margin.
    localparam int SETTLE_CYCLES = 8;
    // Consecutive cycles without any handshake or register write before the run is declared hung.
    localparam int IDLE_LIMIT    = 4000;

    // Request kinds the block decodes but ignores.
    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    int fail_count;
    int pending_count;
    int press_count;
    int release_count;

    // Stimulus bookkeeping and the register values the stimulus is shaped around.
    int items_sent        = 0;
    int filler_items      = 0;
    int settings_loaded   = 0;
    int idle_cycles       = 0;
    int vote_bias         = 80;
    bit sender_quiet      = 1'b0;
    int cur_window_reads  = RST_WINDOW_READS;
    int cur_release_level = RST_RELEASE_LEVEL;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    button_vote_press_release_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    bvpr_event_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .press_count   (press_count),
        .release_count (release_count)
    );

    // Gap length in cycles: none when quiet; otherwise half the time none, mostly short, now and then a long one.
    function automatic int idle_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one item after an optional gap and returns once the block has taken it.
    // The valid is only lowered when a gap follows, so back-to-back items keep it high.
    task automatic send_item(input logic [2:0] req, input logic [7:0] id, input logic flag,
                             input logic power, input logic [31:0] stamp);
        int gap;
        gap = idle_gap(sender_quiet);
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_TDATA_W'({stamp, power, flag, id});
        do @(posedge aclk); while (s_tready !== 1'b1);
        items_sent++;
    endtask

    // Same as send_item with a random power mode and time stamp.
    task automatic send_req(input logic [2:0] req, input logic [7:0] id, input logic flag);
        send_item(req, id, flag, 1'($urandom), $urandom);
    endtask

    // Stops offering items and waits until every predicted event has come out, then
    // waits out a settle time so that a window closing without a winner is finished too.
    task automatic drain_events();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes all four registers on consecutive cycles while the block is idle.
    // The upper nibble of the 4-bit registers carries random junk that must be dropped.
    task automatic load_settings(input int wr, input int mh, input int rl, input int vc);
        drain_events();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_WINDOW_READS;
        cfg_data  <= {4'($urandom), 4'(wr)};
        @(negedge aclk);
        cfg_index <= CFG_MIN_HITS;
        cfg_data  <= {4'($urandom), 4'(mh)};
        @(negedge aclk);
        cfg_index <= CFG_RELEASE_LEVEL;
        cfg_data  <= 8'(rl);
        @(negedge aclk);
        cfg_index <= CFG_VOICE_CODE;
        cfg_data  <= 8'(vc);
        @(negedge aclk) cfg_wr_en <= 1'b0;
        cur_window_reads  = wr & 15;
        cur_release_level = rl & 255;
        settings_loaded++;
    endtask

    // One press and release cycle: detect, a window of samples leaning toward one code,
    // a few samples that keep the code held, then a release by level or by disabling.
    // Some rounds are cut short so that the held samples land inside the window instead.
    task automatic vote_round();
        int         favorite;
        int         reads;
        int         k;
        logic [7:0] id;
        favorite = $urandom_range(0, NUM_CODES - 1);
        reads    = (cur_window_reads == 0) ? 1 : cur_window_reads;
        if ($urandom_range(0, 99) < 15) reads = $urandom_range(0, reads - 1);
        if ($urandom_range(0, 4) == 0) send_req(REQ_BTN_EN, 8'($urandom), 1'b1);
        send_req(REQ_DETECT, 8'($urandom), 1'($urandom));
        for (k = 0; k < reads; k++) begin
            if ($urandom_range(0, 99) < vote_bias) id = 8'(favorite);
            else if ($urandom_range(0, 3) == 0) id = 8'($urandom_range(NUM_CODES, 255));
            else id = 8'($urandom_range(0, NUM_CODES - 1));
            send_req(REQ_SAMPLE, id, 1'($urandom));
        end
        if (cur_release_level > 0) begin
            repeat ($urandom_range(0, 3))
                send_req(REQ_SAMPLE, 8'($urandom_range(0, cur_release_level - 1)),
                         1'($urandom));
        end
        if ($urandom_range(0, 9) == 0) begin
            send_req(REQ_BTN_EN, 8'($urandom), 1'b0);
            send_req(REQ_BTN_EN, 8'($urandom), 1'b1);
        end else begin
            send_req(REQ_SAMPLE, 8'($urandom_range(cur_release_level, 255)), 1'($urandom));
        end
    endtask

    // The receiver takes results in bursts of ready cycles broken by stalls; once in a
    // while it stays ready for a long stretch so that back-to-back traffic is seen as well.
    initial begin : result_pacing
        int run;
        int gap;
        forever begin
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 12);
            @(negedge aclk) m_tready <= 1'b1;
            repeat (run - 1) @(negedge aclk);
            gap = idle_gap(1'b0);
            if (gap > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    end

    // Any accepted item, result or register write counts as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("button_vote_press_release_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int         k;
        int         set_no;
        int         set_start;
        int         wr;
        int         mh;
        int         rl;
        int         vc;
        int         r;
        logic [2:0] kind;

        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Nothing is enabled after reset, so detect, sample and voice change all fall
        // through; the unused request kinds never make an event.
        send_req(REQ_DETECT, 8'h00, 1'b0);
        send_req(REQ_SAMPLE, 8'd3, 1'b0);
        send_req(REQ_VOICE, 8'h00, 1'b0);
        for (k = REQ_UNUSED_LO; k <= REQ_UNUSED_HI; k++) send_req(3'(k), 8'hFF, 1'b1);

        // A second enable must leave the state alone.
        send_req(REQ_BTN_EN, 8'h00, 1'b1);
        send_req(REQ_BTN_EN, 8'h00, 1'b1);

        // Voice line: a low level is a press, a high level a release. Power and
        // time stamp go to both extremes here.
        send_req(REQ_VOICE_EN, 8'h00, 1'b1);
        send_item(REQ_VOICE, 8'h00, 1'b0, 1'b0, 32'h0000_0000);
        send_item(REQ_VOICE, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);

        // Default window of ten samples and seven votes. The second detect is masked.
        // Code 0 gets two votes, one sample is out of range, and the highest code gets
        // seven, so the highest code wins.
        send_req(REQ_DETECT, 8'h00, 1'b0);
        send_req(REQ_DETECT, 8'h00, 1'b0);
        repeat (2) send_req(REQ_SAMPLE, 8'd0, 1'b0);
        send_req(REQ_SAMPLE, 8'hFF, 1'b0);
        repeat (7) send_req(REQ_SAMPLE, 8'(NUM_CODES - 1), 1'b0);

        // Held: just below the release level keeps it, the level itself releases.
        send_req(REQ_SAMPLE, RST_RELEASE_LEVEL - 8'd1, 1'b0);
        send_req(REQ_SAMPLE, RST_RELEASE_LEVEL, 1'b0);

        // Register extremes: a zero window closes on its first sample, zero votes make
        // code 0 win, and with a zero release level every held sample releases.
        load_settings(0, 0, 0, 255);
        send_req(REQ_DETECT, 8'h00, 1'b0);
        send_req(REQ_SAMPLE, 8'hFF, 1'b0);
        send_req(REQ_SAMPLE, 8'h00, 1'b0);

        // Disabling buttons while a code is held releases it.
        send_req(REQ_DETECT, 8'h00, 1'b0);
        send_req(REQ_SAMPLE, 8'd5, 1'b0);
        send_req(REQ_BTN_EN, 8'h00, 1'b0);

        // Disabling buttons during a window drops the window without an event.
        send_req(REQ_BTN_EN, 8'h00, 1'b1);
        send_req(REQ_DETECT, 8'h00, 1'b0);
        send_req(REQ_BTN_EN, 8'h00, 1'b0);

        // Voice events carry the configured voice code; nothing once voice is off.
        send_req(REQ_VOICE, 8'h00, 1'b1);
        send_req(REQ_VOICE_EN, 8'h00, 1'b0);
        send_req(REQ_VOICE, 8'h00, 1'b0);

        // Random part. Every register set starts from an idle, drained block, which also
        // makes the sender wait for all outstanding events. The first two sets are the
        // extremes; the rest are random, with the vote threshold mostly reachable.
        set_no = 0;
        while (items_sent - filler_items < RANDOM_ITEMS) begin
            case (set_no)
                0: begin
                    load_settings(15, 15, 255, 255);
                    vote_bias = 100;
                end
                1: begin
                    load_settings(1, 1, 0, 0);
                    vote_bias = 70;
                end
                default: begin
                    wr = $urandom_range(0, 15);
                    mh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, wr);
                    rl = ($urandom_range(0, 1) == 0) ? $urandom_range(NUM_CODES, 255)
                                                     : $urandom_range(0, 255);
                    vc = $urandom_range(0, 255);
                    load_settings(wr, mh, rl, vc);
                    vote_bias = $urandom_range(60, 100);
                end
            endcase
            sender_quiet = ($urandom_range(0, 3) == 0);
            set_start    = items_sent;
            set_no++;

            while (items_sent - set_start < ITEMS_PER_SET &&
                   items_sent - filler_items < RANDOM_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    vote_round();
                end else if (r < 75) begin
                    if ($urandom_range(0, 2) == 0)
                        send_req(REQ_VOICE_EN, 8'($urandom), ($urandom_range(0, 3) != 0));
                    else
                        send_req(REQ_VOICE, 8'($urandom), 1'($urandom));
                end else if (r < 82) begin
                    send_req(REQ_BTN_EN, 8'($urandom), ($urandom_range(0, 3) != 0));
                end else begin
                    // Filler: any kind, any field value, wherever the block happens to be.
                    kind = 3'($urandom_range(REQ_DETECT, REQ_UNUSED_HI));
                    send_req(kind, 8'($urandom_range(0, 255)), 1'($urandom));
                    filler_items++;
                end
            end
        end

        drain_events();

        $display("Sent %0d items (%0d filler) under %0d register sets plus reset values.",
                 items_sent, filler_items, settings_loaded);
        $display("Checked %0d events: %0d presses and %0d releases, %0d failures.",
                 press_count + release_count, press_count, release_count, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("button_vote_press_release_core: match");
        end else begin
            $display("button_vote_press_release_core: mismatch");
        end
        $finish;
    end

endmodule
